[rtl/hsort_pkg.sv]
// Package for the heap sort core: sizes, value type, controller states and
// the command struct that the controller broadcasts to the cell chain.
// No dependencies.
package hsort_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0]        count_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  // Command broadcast to every cell in the same cycle.
  typedef struct packed {
    logic insert;  // place the input value into its sorted position
    logic pop;     // shift the whole chain one cell towards the output
  } cell_cmd_t;

endpackage

[rtl/hsort_in_if.sv]
// Input channel of the heap sort core: valid/ready handshake with one value
// and its last-of-set marker. Depends on hsort_pkg.
interface hsort_in_if;
  logic             valid;
  logic             ready;
  hsort_pkg::value_t value;
  logic             last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

[rtl/hsort_out_if.sv]
// Output channel of the heap sort core: valid/ready handshake with a sorted
// value, its final-of-set marker and the dropped flag. Depends on hsort_pkg.
interface hsort_out_if;
  logic             valid;
  logic             ready;
  hsort_pkg::value_t sorted_value;
  logic             final_res;
  logic             dropped;

  modport source (output valid, output sorted_value, output final_res, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input dropped,
                  output ready);
endinterface

[rtl/hsort_cell.sv]
// One cell of the sorting chain: holds a single value and hands it to its
// right-hand neighbour on insertion, or takes the right neighbour's on a pop.
// Depends on hsort_pkg.
module hsort_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hsort_pkg::cell_cmd_t  cmd_i,
  input  hsort_pkg::value_t     ins_value_i,
  input  logic                  left_valid_i,
  input  logic                  left_gt_i,
  input  hsort_pkg::value_t     left_value_i,
  input  logic                  right_valid_i,
  input  hsort_pkg::value_t     right_value_i,
  output logic                  valid_o,
  output logic                  gt_o,
  output hsort_pkg::value_t     value_o
);

  logic              valid_q, valid_d;
  hsort_pkg::value_t value_q, value_d;

  // An empty cell behaves as if it held plus infinity.
  assign gt_o = !valid_q || (value_q > ins_value_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (cmd_i.pop) begin
      valid_d = right_valid_i;
      value_d = right_value_i;
    end else if (cmd_i.insert && gt_o) begin
      valid_d = valid_q | left_valid_i;
      value_d = left_gt_i ? left_value_i : ins_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

[rtl/hsort_ctrl.sv]
// Controller of the heap sort core: element count, overflow flag and the
// load/drain state machine that commands the cell chain. Depends on hsort_pkg.
module hsort_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  input  logic                 out_ready_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output logic                 final_res_o,
  output logic                 dropped_o,
  output hsort_pkg::cell_cmd_t cmd_o
);

  hsort_pkg::state_e state_q, state_d;
  hsort_pkg::count_t count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              in_xfer, out_xfer, full;

  assign full     = (count_q == hsort_pkg::count_t'(hsort_pkg::DEPTH));
  assign in_xfer  = in_valid_i && (state_q == hsort_pkg::ST_LOAD);
  assign out_xfer = out_ready_i && (state_q == hsort_pkg::ST_DRAIN);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o.insert = 1'b0;
    cmd_o.pop    = 1'b0;
    case (state_q)
      hsort_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_xfer) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cmd_o.insert = 1'b1;
            count_d      = count_q + 1'b1;
          end
          if (in_last_i) begin
            state_d = hsort_pkg::ST_DRAIN;
          end
        end
      end
      hsort_pkg::ST_DRAIN: begin
        out_valid_o = 1'b1;
        if (out_xfer) begin
          cmd_o.pop = 1'b1;
          count_d   = count_q - 1'b1;
          if (final_res_o) begin
            ovf_d   = 1'b0;
            state_d = hsort_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = hsort_pkg::ST_LOAD;
      end
    endcase
  end

  assign final_res_o = (count_q == hsort_pkg::count_t'(1));
  assign dropped_o   = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsort_pkg::ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

[rtl/heap_sort_core.sv]
// Sorting core: collects a set of signed 32-bit values and returns them in
// ascending order. The set is kept sorted while it loads: a row of DEPTH
// cells, smallest value in cell 0, compares every cell against the incoming
// value in parallel and shifts the larger ones one cell to the right, so an
// insertion completes in the cycle of its transfer. The transfer with last
// set closes the set; from the next cycle on the core delivers one result
// per cycle (as fast as the sink takes them) by shifting the row towards
// cell 0. The input stays stalled while a set is being delivered. Values
// beyond DEPTH are discarded and every result of that set then carries
// dropped; final_res marks the largest, last result.
// Depends on hsort_pkg, hsort_in_if, hsort_out_if, hsort_cell and hsort_ctrl.
module heap_sort_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsort_in_if.sink    in_i,
  hsort_out_if.source out_o
);

  hsort_pkg::cell_cmd_t cmd;
  logic                 cell_valid [hsort_pkg::DEPTH];
  logic                 cell_gt    [hsort_pkg::DEPTH];
  hsort_pkg::value_t    cell_value [hsort_pkg::DEPTH];

  // The controller owns the handshakes and the count of stored values.
  hsort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .final_res_o (out_o.final_res),
    .dropped_o   (out_o.dropped),
    .cmd_o       (cmd)
  );

  // The chain of cells. Cell 0 sees an always-occupied left neighbour that is
  // never greater, so it takes the incoming value whenever it is displaced.
  // The last cell has an empty right neighbour.
  for (genvar g = 0; g < hsort_pkg::DEPTH; g++) begin : g_cell
    logic              left_valid, left_gt, right_valid;
    hsort_pkg::value_t left_value, right_value;

    if (g == 0) begin : g_first
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
      assign left_value = in_i.value;
    end else begin : g_inner
      assign left_valid = cell_valid[g-1];
      assign left_gt    = cell_gt[g-1];
      assign left_value = cell_value[g-1];
    end

    if (g == hsort_pkg::DEPTH - 1) begin : g_end
      assign right_valid = 1'b0;
      assign right_value = '0;
    end else begin : g_mid
      assign right_valid = cell_valid[g+1];
      assign right_value = cell_value[g+1];
    end

    hsort_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .ins_value_i   (in_i.value),
      .left_valid_i  (left_valid),
      .left_gt_i     (left_gt),
      .left_value_i  (left_value),
      .right_valid_i (right_valid),
      .right_value_i (right_value),
      .valid_o       (cell_valid[g]),
      .gt_o          (cell_gt[g]),
      .value_o       (cell_value[g])
    );
  end

  // Results always leave from cell 0, which holds the smallest value left.
  assign out_o.sorted_value = cell_value[0];

endmodule

[rtl/hsort_checker.sv]
// Port-level checker for heap_sort_core, attached by the bind at the end of
// this file. Depends on hsort_pkg and heap_sort_core.
module hsort_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_last_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input hsort_pkg::value_t out_value_i,
  input logic              out_final_i
);

  // No new values are taken while a set is being delivered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input accepted while results are pending");

  // Closing a set makes its first result available in the next cycle.
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> out_valid_i)
    else $error("no result after the last value of a set");

  // A result that is not the final one is followed by another result.
  a_drain_goes_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_final_i) |=> out_valid_i)
    else $error("set delivery ended before its final result");

  // After the final result the core takes input again.
  a_final_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_final_i) |=> (in_ready_i && !out_valid_i))
    else $error("input not reopened after the final result");

  // A stalled result holds its value.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_value_i)))
    else $error("stalled result changed");

endmodule

bind heap_sort_core hsort_checker u_hsort_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.sorted_value),
  .out_final_i (out_o.final_res)
);

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for heap_sort_core: sends sets of signed values and
// checks every sorted result against a predictor kept in step with the input.
// Depends on hsort_pkg, hsort_in_if, hsort_out_if and heap_sort_core.
module testbench;

  // Longest stretch with no transfer on either channel before the run is
  // declared hung.
  localparam int unsigned IDLE_LIMIT = 20000;
  // Cycles allowed after the last expected result before the verdict.
  localparam int unsigned TAIL_CYCLES = 32;
  localparam int unsigned RANDOM_ITEMS = 100;

  typedef struct {
    hsort_pkg::value_t sorted_value;
    logic              final_res;
    logic              dropped;
  } sort_result_t;

  logic clk = 1'b0;
  logic rst_n;

  hsort_in_if  in_ch ();
  hsort_out_if out_ch ();

  heap_sort_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Predictor state: the set being collected, whether part of it was lost
  // for lack of room, and the results the core still owes us, oldest first.
  hsort_pkg::value_t set_values[$];
  logic              set_overflow;
  sort_result_t      expected_results[$];

  int unsigned error_count;
  int unsigned idle_cycles = 0;
  int unsigned results_seen;
  bit          src_idle_en;
  bit          sink_idle_en;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Mirrors the core for one accepted transfer. A value that finds the store
  // full is thrown away; the transfer with last closes the set and queues its
  // values in ascending order.
  function automatic void record_element(input hsort_pkg::value_t v, input logic lst);
    hsort_pkg::value_t sorted[$];
    hsort_pkg::value_t key;
    sort_result_t      res;
    int                i;
    int                j;
    if (set_values.size() < hsort_pkg::DEPTH) begin
      set_values.push_back(v);
    end else begin
      set_overflow = 1'b1;
    end
    if (lst) begin
      sorted = set_values;
      for (i = 1; i < sorted.size(); i++) begin
        key = sorted[i];
        j   = i - 1;
        while (j >= 0 && sorted[j] > key) begin
          sorted[j+1] = sorted[j];
          j--;
        end
        sorted[j+1] = key;
      end
      for (i = 0; i < sorted.size(); i++) begin
        res.sorted_value = sorted[i];
        res.final_res    = (i == sorted.size() - 1);
        res.dropped      = set_overflow;
        expected_results.push_back(res);
      end
      set_values.delete();
      set_overflow = 1'b0;
    end
  endfunction

  // Sends one value. valid is left high after the transfer so that a
  // back-to-back item never lowers and raises it within one time step.
  task automatic send_element(input hsort_pkg::value_t v, input logic lst);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= lst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    record_element(v, lst);
  endtask

  // Mixes full-range values with a narrow band around zero (to force ties)
  // and the extremes of the range.
  function automatic hsort_pkg::value_t draw_value();
    hsort_pkg::value_t v;
    case ($urandom_range(0, 3))
      0, 1:    v = hsort_pkg::value_t'($urandom);
      2:       v = hsort_pkg::value_t'($urandom_range(0, 8)) - hsort_pkg::value_t'(4);
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7FFF_FFFF;
          2:       v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_random_set(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      send_element(draw_value(), k == n - 1);
    end
  endtask

  // A set of one value, the smallest there is.
  task automatic test_single_element();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_element(32'sh8000_0000, 1'b1);
  endtask

  task automatic test_two_elements();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b0;
    send_element(32'sh7FFF_FFFF, 1'b0);
    send_element(32'sh8000_0000, 1'b1);
  endtask

  // Extremes and alternating bit patterns, so every value bit toggles.
  task automatic test_extremes();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b1;
    send_element(32'sh7FFF_FFFF, 1'b0);
    send_element(32'sh5555_5555, 1'b0);
    send_element(32'sh0000_0000, 1'b0);
    send_element(32'shFFFF_FFFF, 1'b0);
    send_element(32'shAAAA_AAAA, 1'b0);
    send_element(32'sh0000_0001, 1'b0);
    send_element(32'sh8000_0000, 1'b1);
  endtask

  // Duplicates must all come back.
  task automatic test_equal_values();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_element(32'sd7, 1'b0);
    send_element(32'sd7, 1'b0);
    send_element(-32'sd3, 1'b0);
    send_element(32'sd7, 1'b1);
  endtask

  // Exactly fills the store: nothing may be flagged as dropped.
  task automatic test_full_store();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b1;
    send_random_set(hsort_pkg::DEPTH);
  endtask

  // One value too many, and the surplus one is the closing transfer itself;
  // a short set afterwards must come back clean again.
  task automatic test_overflow();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b0;
    send_random_set(hsort_pkg::DEPTH + 1);
    send_random_set(3);
  endtask

  // Mostly short sets, some medium ones, now and then a full or overflowing
  // store. Idling on each side is switched per set so that long stretches
  // run at full rate too.
  task automatic test_random_sets();
    int unsigned sent;
    int unsigned n;
    int unsigned pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        n = $urandom_range(1, 8);
      end else if (pick < 18) begin
        n = $urandom_range(9, 40);
      end else if (pick == 18) begin
        n = hsort_pkg::DEPTH;
      end else begin
        n = $urandom_range(hsort_pkg::DEPTH + 1, hsort_pkg::DEPTH + 6);
      end
      src_idle_en  = ($urandom_range(0, 2) != 0);
      sink_idle_en = ($urandom_range(0, 2) != 0);
      send_random_set(n);
      sent += n;
    end
  endtask

  // Result side: stalls at random, then takes one transfer and compares it
  // with the oldest expectation.
  initial begin : result_monitor
    int           stall;
    sort_result_t want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = sink_idle_en ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d (final_res %b, dropped %b)",
                                  out_ch.sorted_value, out_ch.final_res, out_ch.dropped));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.sorted_value !== want.sorted_value) begin
          report_mismatch($sformatf("result %0d: sorted_value %0d, expected %0d",
                                    results_seen, out_ch.sorted_value, want.sorted_value));
        end
        if (out_ch.final_res !== want.final_res) begin
          report_mismatch($sformatf("result %0d: final_res %b, expected %b",
                                    results_seen, out_ch.final_res, want.final_res));
        end
        if (out_ch.dropped !== want.dropped) begin
          report_mismatch($sformatf("result %0d: dropped %b, expected %b",
                                    results_seen, out_ch.dropped, want.dropped));
        end
      end
      results_seen++;
    end
  end

  // Hang detection: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    error_count  = 0;
    results_seen = 0;
    set_overflow = 1'b0;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_element();
    test_two_elements();
    test_extremes();
    test_equal_values();
    test_full_store();
    test_overflow();
    test_random_sets();

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[heap_sort_core.f]
rtl/hsort_pkg.sv
rtl/hsort_in_if.sv
rtl/hsort_out_if.sv
rtl/hsort_cell.sv
rtl/hsort_ctrl.sv
rtl/heap_sort_core.sv
rtl/hsort_checker.sv
bench/testbench.sv
